>>> hw/rtl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg: shared constants and the generator step
// Holds the request codes, register indexes, seed reset values and the
// multiply-with-carry half-step used by the random source.
// ----------------------------------------------------------------------------
`default_nettype none

package mwc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CntW    = 5;

  // Request codes
  localparam logic [FuncW-1:0] FUNC_WORD32  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_PIECE16 = 2'd1;
  localparam logic [FuncW-1:0] FUNC_PIECE8  = 2'd2;
  localparam logic [FuncW-1:0] FUNC_BOUNDED = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SEED_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SEED_LOW  = 1'b1;

  localparam logic [WordW-1:0] SEED_HIGH_RESET = 32'd362436069;
  localparam logic [WordW-1:0] SEED_LOW_RESET  = 32'd521288629;

  localparam logic [HalfW-1:0] MULT_HIGH = 16'd36969;
  localparam logic [HalfW-1:0] MULT_LOW  = 16'd18000;

  // One half step: mult * low16 + high16
  function automatic logic [WordW-1:0] mwc_advance(input logic [WordW-1:0] x,
                                                   input logic [HalfW-1:0] mult);
    logic [WordW-1:0] prod;
    prod = {16'd0, x[HalfW-1:0]} * {16'd0, mult};
    mwc_advance = prod + {16'd0, x[WordW-1:HalfW]};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mwc_random_source.sv
// ----------------------------------------------------------------------------
// mwc_random_source: multiply-with-carry random source
// Serves word, 16-bit piece, 8-bit piece and bounded requests from one
// two-half multiply-with-carry generator.
// ----------------------------------------------------------------------------
// Word and piece requests finish in the accept cycle and their result is
// offered on the next cycle. A bounded request with a nonzero bound normalizes
// the bound one bit per cycle, draws one word per cycle until a word falls
// below the normalized threshold (usually one or two draws), then computes the
// remainder with a restoring divider, one quotient bit per cycle, on a single
// shared 33-bit subtractor. A bound of zero returns zero at once and leaves the
// generator alone.
// One request is in flight at a time; a new request is taken on the cycle after
// the previous result has been taken. Seed writes reload a generator half and
// restart both piece splits.
`default_nettype none

module mwc_random_source
  import mwc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire [FuncW-1:0]     func_i,
  input  wire [WordW-1:0]     bound_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [WordW-1:0]    value_o,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [WordW-1:0]     cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_DRAW = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [WordW-1:0] gen_high_q, gen_low_q;
  logic             half_left_q;
  logic [WordW-1:0] half_word_q;
  logic [1:0]       byte_left_q;
  logic [WordW-1:0] byte_word_q;
  logic [WordW-1:0] thr_q, bound_q, val_q, rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;
  logic [WordW-1:0] out_value_q;

  logic             in_acc, out_acc;
  logic [WordW-1:0] gen_high_nx, gen_low_nx, word_nx;
  logic             advance;

  // shared subtractor
  logic [WordW:0]   sub_a, sub_b;
  logic [WordW+1:0] sub_diff;
  logic             sub_borrow;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

  assign gen_high_nx = mwc_advance(gen_high_q, MULT_HIGH);
  assign gen_low_nx  = mwc_advance(gen_low_q, MULT_LOW);
  assign word_nx     = {gen_high_nx[HalfW-1:0], 16'd0} + gen_low_nx;

  always_comb begin
    if (state_q == S_DIV) begin
      sub_a = {rem_q, val_q[WordW-1]};
      sub_b = {1'b0, bound_q};
    end else begin
      sub_a = {1'b0, word_nx};
      sub_b = {1'b0, thr_q};
    end
    sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    sub_borrow = sub_diff[WordW+1];
  end

  always_comb begin
    advance = 1'b0;
    if (in_acc) begin
      case (func_i)
        FUNC_WORD32:  advance = 1'b1;
        FUNC_PIECE16: advance = !half_left_q;
        FUNC_PIECE8:  advance = (byte_left_q == 2'd0);
        default:      advance = 1'b0;
      endcase
    end else if (state_q == S_DRAW) begin
      advance = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && func_i == FUNC_BOUNDED && bound_i != '0) state_d = S_NORM;
      end
      S_NORM: begin
        if (thr_q[WordW-1]) state_d = S_DRAW;
      end
      S_DRAW: begin
        if (sub_borrow) state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == '0) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_high_q  <= SEED_HIGH_RESET;
      gen_low_q   <= SEED_LOW_RESET;
      half_left_q <= 1'b0;
      half_word_q <= '0;
      byte_left_q <= 2'd0;
      byte_word_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_acc) out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEED_HIGH: gen_high_q <= cfg_wdata_i;
          REG_SEED_LOW:  gen_low_q  <= cfg_wdata_i;
          default:       gen_low_q  <= cfg_wdata_i;
        endcase
        half_left_q <= 1'b0;
        byte_left_q <= 2'd0;
      end else if (advance) begin
        gen_high_q <= gen_high_nx;
        gen_low_q  <= gen_low_nx;
      end

      if (in_acc) begin
        case (func_i)
          FUNC_WORD32: begin
            out_valid_q <= 1'b1;
          end
          FUNC_PIECE16: begin
            half_left_q <= !half_left_q;
            half_word_q <= half_left_q ? (half_word_q >> HalfW) : word_nx;
            out_valid_q <= 1'b1;
          end
          FUNC_PIECE8: begin
            byte_left_q <= byte_left_q - 2'd1;
            byte_word_q <= (byte_left_q != 2'd0) ? (byte_word_q >> 8) : word_nx;
            out_valid_q <= 1'b1;
          end
          default: begin
            // zero bound answers at once
            if (bound_i == '0) out_valid_q <= 1'b1;
          end
        endcase
      end else if (state_q == S_DIV && cnt_q == '0) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      thr_q   <= bound_i;
      bound_q <= bound_i;
      case (func_i)
        FUNC_WORD32:  out_value_q <= word_nx;
        FUNC_PIECE16: out_value_q <= half_left_q ? {16'd0, half_word_q[WordW-1:HalfW]}
                                                 : {16'd0, word_nx[HalfW-1:0]};
        FUNC_PIECE8:  out_value_q <= (byte_left_q != 2'd0) ? {24'd0, byte_word_q[15:8]}
                                                           : {24'd0, word_nx[7:0]};
        default:      out_value_q <= '0;
      endcase
    end
    case (state_q)
      S_NORM: begin
        if (!thr_q[WordW-1]) thr_q <= thr_q << 1;
      end
      S_DRAW: begin
        // redraw until the word falls below the threshold
        val_q <= word_nx;
        rem_q <= '0;
        cnt_q <= CntW'(WordW - 1);
      end
      S_DIV: begin
        rem_q <= sub_borrow ? sub_a[WordW-1:0] : sub_diff[WordW-1:0];
        val_q <= val_q << 1;
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) out_value_q <= sub_borrow ? sub_a[WordW-1:0] : sub_diff[WordW-1:0];
      end
      default: begin
      end
    endcase
  end

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result pending while a bounded request is still running");

  a_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < bound_q))
    else $error("partial remainder not below bound");

  a_thr_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW) |-> thr_q[WordW-1])
    else $error("drawing against an unnormalized threshold");

  a_zero_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FUNC_BOUNDED && bound_i == '0)
      |=> (out_valid_q && out_value_q == '0 && state_q == S_IDLE))
    else $error("zero bound did not return zero at once");

  a_gen_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !cfg_we_i) |=> $stable(gen_high_q) && $stable(gen_low_q))
    else $error("generator moved during the remainder pass");

endmodule

`default_nettype wire

>>> verif/tb_mwc_random_source.sv
// ----------------------------------------------------------------------------
// tb_mwc_random_source: self-checking bench for the multiply-with-carry source
// Requests words, 16-bit and 8-bit pieces and bounded draws under several
// seeds and idle patterns. Each result is compared with an in-bench generator
// that tracks both generator halves and both piece splits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mwc_random_source;
  import mwc_pkg::*;

  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned CFG_HOLD    = 4;
  localparam int unsigned END_HOLD    = 80;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned MAX_REPORTS = 10;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [FuncW-1:0]     func_i      = FUNC_WORD32;
  logic [WordW-1:0]     bound_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [WordW-1:0]     value_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = REG_SEED_HIGH;
  logic [WordW-1:0]     cfg_wdata_i = '0;

  // generator mirror
  logic [WordW-1:0] gen_hi, gen_lo;
  logic             split16_left;
  logic [WordW-1:0] split16_word;
  logic [1:0]       split8_left;
  logic [WordW-1:0] split8_word;

  logic [WordW-1:0] pending_values[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;
  int unsigned n_results      = 0;
  int unsigned n_seed_writes  = 0;
  int unsigned n_redraws      = 0;
  int unsigned n_requests[4]  = '{0, 0, 0, 0};
  int unsigned quiet_cycles   = 0;

  mwc_random_source i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .bound_i     (bound_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Advance both halves once and combine them into a 32-bit word.
  function automatic logic [WordW-1:0] draw_mwc_word();
    gen_hi = 32'd36969 * {16'd0, gen_hi[15:0]} + {16'd0, gen_hi[31:16]};
    gen_lo = 32'd18000 * {16'd0, gen_lo[15:0]} + {16'd0, gen_lo[31:16]};
    return (gen_hi << 16) + gen_lo;
  endfunction

  function automatic logic [WordW-1:0] next_random_value(input logic [FuncW-1:0] f,
                                                          input logic [WordW-1:0] b);
    logic [WordW-1:0] threshold;
    logic [WordW-1:0] w;
    case (f)
      FUNC_WORD32: begin
        return draw_mwc_word();
      end
      FUNC_PIECE16: begin
        if (split16_left) begin
          split16_left = 1'b0;
          split16_word = split16_word >> 16;
        end else begin
          split16_left = 1'b1;
          split16_word = draw_mwc_word();
        end
        return {16'd0, split16_word[15:0]};
      end
      FUNC_PIECE8: begin
        if (split8_left != 2'd0) begin
          split8_left = split8_left - 2'd1;
          split8_word = split8_word >> 8;
        end else begin
          split8_left = 2'd3;
          split8_word = draw_mwc_word();
        end
        return {24'd0, split8_word[7:0]};
      end
      default: begin
        // zero bound: answer zero, leave the generator where it is
        if (b == '0) return '0;
        threshold = b;
        while (!threshold[WordW-1]) threshold = threshold << 1;
        w = draw_mwc_word();
        while (w >= threshold) begin
          n_redraws++;
          w = draw_mwc_word();
        end
        return w % b;
      end
    endcase
  endfunction

  // Hold the request until accepted, then record what it must return.
  task automatic send_request(input logic [FuncW-1:0] f, input logic [WordW-1:0] b);
    while (chance(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    bound_i    <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_values.push_back(next_random_value(f, b));
    n_requests[f]++;
  endtask

  // Drop the request line and hold until every result is back.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (CFG_HOLD) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SEED_HIGH) gen_hi = val;
    else gen_lo = val;
    split16_left = 1'b0;
    split8_left  = 2'd0;
    n_seed_writes++;
    @(posedge clk_i);
  endtask

  // The 16-bit split must keep its saved word across word draws.
  task automatic test_reset_sequence();
    send_request(FUNC_WORD32, '0);
    send_request(FUNC_PIECE16, '0);
    send_request(FUNC_WORD32, 32'hFFFFFFFF);
    send_request(FUNC_PIECE16, '0);
    send_request(FUNC_PIECE16, '0);
    repeat (5) send_request(FUNC_PIECE8, 32'hFFFFFFFF);
    wait_results_done();
  endtask

  task automatic test_bounded_edges();
    send_request(FUNC_BOUNDED, 32'd0);
    send_request(FUNC_BOUNDED, 32'd1);
    send_request(FUNC_BOUNDED, 32'd2);
    send_request(FUNC_BOUNDED, 32'd3);
    send_request(FUNC_BOUNDED, 32'h7FFFFFFF);
    send_request(FUNC_BOUNDED, 32'h80000000);
    send_request(FUNC_BOUNDED, 32'h80000001);
    send_request(FUNC_BOUNDED, 32'hFFFFFFFF);
    wait_results_done();
  endtask

  // Seed writes restart both splits; a zero seed pins its half at zero.
  task automatic test_seed_writes();
    send_request(FUNC_PIECE16, '0);
    send_request(FUNC_PIECE8, '0);
    wait_results_done();
    write_seed(REG_SEED_HIGH, 32'd1);
    write_seed(REG_SEED_LOW, 32'hFFFFFFFF);
    send_request(FUNC_PIECE16, '0);
    send_request(FUNC_PIECE8, '0);
    wait_results_done();
    write_seed(REG_SEED_HIGH, 32'd0);
    write_seed(REG_SEED_LOW, 32'd0);
    send_request(FUNC_WORD32, '0);
    send_request(FUNC_BOUNDED, 32'd12345);
    send_request(FUNC_PIECE8, '0);
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [FuncW-1:0] f;
    logic [WordW-1:0] b;
    write_seed(REG_SEED_HIGH, $urandom_range(32'hFFFFFFFF, 1));
    write_seed(REG_SEED_LOW, $urandom_range(32'hFFFFFFFF, 1));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      f = FuncW'($urandom_range(3));
      case ($urandom_range(9))
        0:       b = '0;
        1, 2:    b = $urandom_range(16, 1);
        3, 4:    b = 32'd1 << $urandom_range(31);
        5:       b = 32'hFFFFFFFF - $urandom_range(15);
        default: b = $urandom;
      endcase
      send_request(f, b);
      if (chance(2)) wait_results_done();
    end
    wait_results_done();
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= !chance(recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [WordW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_values.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("ERROR: result 0x%08h with no request outstanding", value_o);
        fail_count++;
      end else begin
        want = pending_values.pop_front();
        if (value_o !== want) begin
          if (fail_count < MAX_REPORTS)
            $display("ERROR: result %0d value expected 0x%08h got 0x%08h",
                     n_results, want, value_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_values.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gen_hi       = SEED_HIGH_RESET;
    gen_lo       = SEED_LOW_RESET;
    split16_left = 1'b0;
    split16_word = '0;
    split8_left  = 2'd0;
    split8_word  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_sequence();
    test_bounded_edges();
    test_seed_writes();
    test_random_traffic(0, 0);
    test_random_traffic(47, 0);
    test_random_traffic(0, 47);
    test_random_traffic(8, 8);

    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (END_HOLD) @(posedge clk_i);
    if (pending_values.size() != 0) begin
      $display("ERROR: %0d results never arrived", pending_values.size());
      fail_count++;
    end

    $display("Covered %0d words, %0d 16-bit pieces, %0d 8-bit pieces, %0d bounded draws",
             n_requests[0], n_requests[1], n_requests[2], n_requests[3]);
    $display("Checked %0d results across %0d seed writes; %0d rejected draws, %0d errors",
             n_results, n_seed_writes, n_redraws, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
